### rtl/cpv_pkg.sv
// ----------------------------------------------------------------------------
// cpv_pkg
// Shared widths, word types and the arctangent table for the cartesian to
// polar vector block.
// ----------------------------------------------------------------------------
package cpv_pkg;

    // coordinate and fixed-point formats
    localparam int COORD_BITS     = 16;
    localparam int ROTATION_STEPS = 16;
    localparam int FRAC_BITS      = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int ROT_STAGES     = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS
                                                                    : ATAN_ENTRIES;
    localparam int STEP_W         = 5;

    // displacement, vector and angle widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int VEC_W  = COORD_BITS + FRAC_BITS + 4;
    localparam int ANG_W  = 32;
    localparam int DIST_W = COORD_BITS + 1;
    localparam int HEAD_W = 16;

    // gain compensation split: low 32 bits and the remaining high part
    localparam int XH_W   = (VEC_W > 32) ? (VEC_W - 32) : 1;
    localparam int UX_W   = 32 + XH_W;
    localparam int PROD_W = UX_W + 1;

    localparam logic [31:0]      GAIN_INV_Q32 = 32'h9B74_EDA8;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;

    // input and result words
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [HEAD_W-1:0] heading;
    } out_word_t;

    // state carried through the rotation stages
    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ANG_W-1:0]        z;
    } cordic_t;

    // atan(2^-i) in units of 2^32 per turn, truncated
    function automatic logic [ANG_W-1:0] atan_turn32(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] a;
        case (idx)
            5'd0:    a = 32'h2000_0000;
            5'd1:    a = 32'h12E4_051D;
            5'd2:    a = 32'h09FB_385B;
            5'd3:    a = 32'h0511_11D4;
            5'd4:    a = 32'h028B_0D43;
            5'd5:    a = 32'h0145_D7E1;
            5'd6:    a = 32'h00A2_F61E;
            5'd7:    a = 32'h0051_7C55;
            5'd8:    a = 32'h0028_BE53;
            5'd9:    a = 32'h0014_5F2E;
            5'd10:   a = 32'h000A_2F98;
            5'd11:   a = 32'h0005_17CC;
            5'd12:   a = 32'h0002_8BE6;
            5'd13:   a = 32'h0001_45F3;
            5'd14:   a = 32'h0000_A2F9;
            5'd15:   a = 32'h0000_517C;
            5'd16:   a = 32'h0000_28BE;
            5'd17:   a = 32'h0000_145F;
            5'd18:   a = 32'h0000_0A2F;
            5'd19:   a = 32'h0000_0517;
            5'd20:   a = 32'h0000_028B;
            5'd21:   a = 32'h0000_0145;
            5'd22:   a = 32'h0000_00A2;
            5'd23:   a = 32'h0000_0051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/cpv_stage.sv
// ----------------------------------------------------------------------------
// cpv_stage
// One registered micro-rotation of the vectoring CORDIC: drives y towards
// zero and accumulates the turned angle.
// ----------------------------------------------------------------------------
module cpv_stage
    import cpv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  logic              in_vld,
    input  cordic_t           in_st,
    output logic              out_vld,
    output cordic_t           out_st
);

    logic    vld_reg;
    cordic_t st_reg;
    cordic_t st_next;

    // rotate towards the x axis, floor shifts on both components
    always_comb begin
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic [ANG_W-1:0]        a;
        xs = in_st.x >>> step;
        ys = in_st.y >>> step;
        a  = atan_turn32(step);
        st_next.zero = in_st.zero;
        if (in_st.y > 0) begin
            st_next.x = in_st.x + ys;
            st_next.y = in_st.y - xs;
            st_next.z = in_st.z + a;
        end else begin
            st_next.x = in_st.x - ys;
            st_next.y = in_st.y + xs;
            st_next.z = in_st.z - a;
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_st  = st_reg;

endmodule

### rtl/cartesian_to_polar_vector.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_vector
// Distance and heading from a start point to an end point, by a fully
// pipelined vectoring CORDIC with gain compensation.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           word
//  s_        in         s_valid / s_ready   start_x, start_y, end_x, end_y
//  m_        out        m_valid / m_ready   distance, heading
//
//  One word is taken every clock while the skid register is empty; from
//  acceptance to m_valid a word passes the difference, pre-rotation, one
//  register per micro-rotation, gain multiply, rounding and output registers.
//  The pipeline moves as a whole; it holds while the skid register is full,
//  and s_ready is that register's empty flag, so no path runs from m_ready
//  to s_ready. Reset clears the valid bits only.
//
module cartesian_to_polar_vector
    import cpv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic en;
    logic push;

    logic                     d_vld_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;

    logic    rot_vld [0:ROT_STAGES];
    cordic_t rot_st  [0:ROT_STAGES];
    logic    p_vld_reg;
    cordic_t p_st_reg;
    cordic_t p_st_next;

    logic              g_vld_reg;
    logic              g_zero_reg;
    logic [63:0]       lo_prod_reg;
    logic [UX_W-1:0]   hi_prod_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [63:0]       lo_prod_next;
    logic [UX_W-1:0]   hi_prod_next;
    logic [HEAD_W-1:0] head_next;

    logic      r_vld_reg;
    out_word_t r_reg;
    out_word_t r_next;

    logic      m_vld_reg;
    out_word_t m_reg;
    logic      skid_vld_reg;
    out_word_t skid_reg;

    // whole pipeline advances unless the skid register holds a word
    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign push    = en && r_vld_reg;

    // displacement
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= {s_data.end_x[COORD_BITS-1], s_data.end_x}
                    - {s_data.start_x[COORD_BITS-1], s_data.start_x};
            dy_reg <= {s_data.end_y[COORD_BITS-1], s_data.end_y}
                    - {s_data.start_y[COORD_BITS-1], s_data.start_y};
        end
    end

    // scale to fixed point, fold the left half plane by half a turn
    always_comb begin
        logic signed [VEC_W-1:0] px;
        logic signed [VEC_W-1:0] py;
        px = {{(VEC_W-DIFF_W-FRAC_BITS){dx_reg[DIFF_W-1]}}, dx_reg, {FRAC_BITS{1'b0}}};
        py = {{(VEC_W-DIFF_W-FRAC_BITS){dy_reg[DIFF_W-1]}}, dy_reg, {FRAC_BITS{1'b0}}};
        p_st_next.zero = (dx_reg == '0) && (dy_reg == '0);
        if (dx_reg < 0) begin
            p_st_next.x = -px;
            p_st_next.y = -py;
            p_st_next.z = HALF_TURN;
        end else begin
            p_st_next.x = px;
            p_st_next.y = py;
            p_st_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_st_reg <= p_st_next;
        end
    end

    assign rot_vld[0] = p_vld_reg;
    assign rot_st[0]  = p_st_reg;

    // micro-rotation chain
    for (genvar g = 0; g < ROT_STAGES; g++) begin : g_rot
        cpv_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .step    (STEP_W'(g)),
            .in_vld  (rot_vld[g]),
            .in_st   (rot_st[g]),
            .out_vld (rot_vld[g+1]),
            .out_st  (rot_st[g+1])
        );
    end

    // gain compensation multiply, split into the low 32 bits and the high XH_W bits; heading rounding
    always_comb begin
        logic [VEC_W-1:0] ux;
        logic [UX_W-1:0]  ux_ext;
        logic [31:0]      xl;
        logic [XH_W-1:0]  xh;
        ux     = rot_st[ROT_STAGES].x[VEC_W-1] ? '0 : rot_st[ROT_STAGES].x;
        ux_ext = UX_W'(ux);
        xl     = ux_ext[31:0];
        xh     = ux_ext[32 +: XH_W];
        lo_prod_next = 64'(xl) * 64'(GAIN_INV_Q32);
        hi_prod_next = UX_W'(xh) * UX_W'(GAIN_INV_Q32);
        head_next    = rot_st[ROT_STAGES].z[ANG_W-1 -: HEAD_W]
                     + HEAD_W'(rot_st[ROT_STAGES].z[ANG_W-HEAD_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (en) begin
            g_vld_reg <= rot_vld[ROT_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_zero_reg  <= rot_st[ROT_STAGES].zero;
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
            head_reg    <= head_next;
        end
    end

    // sum the partial products and round to whole units
    always_comb begin
        logic [PROD_W-1:0] rnd;
        rnd = PROD_W'(hi_prod_reg) + PROD_W'(lo_prod_reg[63:32])
            + (PROD_W'(1) << (FRAC_BITS - 1));
        if (g_zero_reg) begin
            r_next.distance = '0;
            r_next.heading  = '0;
        end else begin
            r_next.distance = rnd[FRAC_BITS +: DIST_W];
            r_next.heading  = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg <= 1'b0;
        end else if (en) begin
            r_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    // output register with skid word behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (m_vld_reg && m_ready) begin
                if (skid_vld_reg) begin
                    m_vld_reg    <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end else begin
                    m_vld_reg <= push;
                end
            end else if (!m_vld_reg) begin
                m_vld_reg <= push;
            end else if (push) begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((m_vld_reg && m_ready) || !m_vld_reg) begin
            m_reg <= skid_vld_reg ? skid_reg : r_reg;
        end
        if (m_vld_reg && !m_ready && push) begin
            skid_reg <= r_reg;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_reg;

endmodule
